// File: src/msblt_pkg.sv
// Shared types, constants and helpers of the masked sprite page blitter.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package msblt_pkg;

	// default screen geometry
	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;

	// store address width that covers the largest screen (512 x 256 pixels)
	localparam int ADDR_W = 14;

	// depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// operation codes carried in tuser
	localparam logic [1:0] OP_SPRITE = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// draw modes
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_XOR    = 2'd1;

	// register indexes on the configuration port
	localparam logic [2:0] REG_POS_X       = 3'd0;
	localparam logic [2:0] REG_POS_Y       = 3'd1;
	localparam logic [2:0] REG_SPRITE_W    = 3'd2;
	localparam logic [2:0] REG_SPRITE_H    = 3'd3;
	localparam logic [2:0] REG_MIRROR_H    = 3'd4;
	localparam logic [2:0] REG_MIRROR_V    = 3'd5;
	localparam logic [2:0] REG_DRAW_MODE   = 3'd6;
	localparam logic [2:0] REG_HAS_MASK    = 3'd7;

	typedef logic [ADDR_W-1:0] addr_t;

	// configuration registers as seen by the front
	typedef struct packed {
		logic signed [8:0] pos_x;
		logic signed [7:0] pos_y;
		logic [7:0]        sprite_width;
		logic [7:0]        sprite_height;
		logic              mirror_h;
		logic              mirror_v;
		logic [1:0]        draw_mode;
		logic              has_mask;
	} cfg_t;

	// one store access: a read, or a read-modify-write merge
	typedef struct packed {
		logic       is_read;
		logic       rd_zero;
		logic       xor_mode;
		addr_t      addr;
		logic [7:0] data;
		logic [7:0] mask;
	} mem_op_t;

	// one queued job: one or two store accesses
	typedef struct packed {
		mem_op_t op_a;
		mem_op_t op_b;
		logic    two;
	} job_t;

	// reverse the bit order of a byte
	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		begin
			r = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
			r = ((r & 8'hCC) >> 2) | ((r & 8'h33) << 2);
			r = ((r & 8'hAA) >> 1) | ((r & 8'h55) << 1);
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// File: src/msblt_queue.sv
// Short job queue between the blitter front and back.
// Depends on msblt_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module msblt_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  msblt_pkg::job_t     push_job,
	output logic                full,
	input  wire                 pop,
	output logic                head_valid,
	output msblt_pkg::job_t     head_job
);

	localparam int Depth = msblt_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	msblt_pkg::job_t    entry_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/msblt_front.sv
// Blitter front: accepts input transfers, keeps the sprite stream counters and
// turns each item that touches the screen, and every read, into a job of store accesses. Depends on msblt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msblt_front #(
	parameter int SCREEN_WIDTH  = msblt_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = msblt_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  msblt_pkg::cfg_t     cfg,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [1:0]          operation,
	input  wire  [7:0]          sprite_byte,
	input  wire  [7:0]          mask_byte,
	input  wire  [9:0]          fb_address,
	input  wire  [7:0]          fb_data,
	input  wire                 queue_full,
	output logic                job_push,
	output msblt_pkg::job_t     job
);

	localparam int ScreenPages = SCREEN_HEIGHT / 8;
	localparam int FbBytes     = SCREEN_WIDTH * ScreenPages;

	logic [7:0]  src_column_q;
	logic [4:0]  src_page_q;

	logic [8:0]  pages_sum;
	logic [5:0]  pages;
	logic        empty;
	logic [7:0]  col;
	logic [4:0]  pg;
	logic [7:0]  mask_v;
	logic [7:0]  data_v;
	logic [7:0]  data_m;
	logic [7:0]  mask_m;
	logic [2:0]  yo;
	logic [7:0]  dcol;
	logic [5:0]  dpage_full;
	logic [4:0]  dpage;
	logic [6:0]  row0;
	logic [6:0]  row1;
	logic [9:0]  scol;
	logic        col_ok;
	logic        row0_ok;
	logic        row1_ok;
	logic        a_ok;
	logic        b_ok;
	logic [15:0] bits;
	logic [15:0] mbits;
	msblt_pkg::addr_t addr0;
	msblt_pkg::addr_t addr1;
	msblt_pkg::mem_op_t op0;
	msblt_pkg::mem_op_t op1;
	logic [8:0]  col_inc;
	logic [5:0]  pg_inc;
	logic [7:0]  col_next;
	logic [4:0]  pg_next;
	logic        fb_in_range;
	logic        job_ok;
	logic        accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// sprite geometry and source position
	always_comb begin
		pages_sum = {1'b0, cfg.sprite_height} + 9'd7;
		pages     = pages_sum[8:3];
		empty     = (cfg.sprite_width == 8'd0) || (pages == 6'd0);
		col       = (src_column_q >= cfg.sprite_width) ? 8'd0 : src_column_q;
		pg        = ({1'b0, src_page_q} >= pages) ? 5'd0 : src_page_q;
	end

	// data and mask after draw mode and vertical mirroring
	always_comb begin
		mask_v = cfg.has_mask ? mask_byte : 8'hFF;
		data_v = (cfg.draw_mode != msblt_pkg::MODE_NORMAL) ? (~sprite_byte & mask_v)
			: sprite_byte;
		data_m = cfg.mirror_v ? msblt_pkg::rev8(data_v) : data_v;
		mask_m = cfg.mirror_v ? msblt_pkg::rev8(mask_v) : mask_v;
		yo     = cfg.pos_y[2:0];
		bits   = {8'd0, data_m} << yo;
		mbits  = {8'd0, mask_m} << yo;
	end

	// destination column and pages with clipping
	always_comb begin
		dcol       = cfg.mirror_h ? (cfg.sprite_width - 8'd1 - col) : col;
		dpage_full = cfg.mirror_v ? (pages - 6'd1 - {1'b0, pg}) : {1'b0, pg};
		dpage      = dpage_full[4:0];
		row0       = {{2{cfg.pos_y[7]}}, cfg.pos_y[7:3]} + {2'b00, dpage};
		row1       = row0 + 7'd1;
		scol       = {cfg.pos_x[8], cfg.pos_x} + {2'b00, dcol};
		col_ok     = !scol[9] && (scol < 10'(SCREEN_WIDTH));
		row0_ok    = !row0[6] && (row0 < 7'(ScreenPages));
		row1_ok    = !row1[6] && (row1 < 7'(ScreenPages)) && (yo != 3'd0);
		a_ok       = col_ok && row0_ok;
		b_ok       = col_ok && row1_ok;
		addr0      = msblt_pkg::addr_t'(row0[5:0]) * msblt_pkg::addr_t'(SCREEN_WIDTH)
			+ msblt_pkg::addr_t'(scol[8:0]);
		addr1      = msblt_pkg::addr_t'(row1[5:0]) * msblt_pkg::addr_t'(SCREEN_WIDTH)
			+ msblt_pkg::addr_t'(scol[8:0]);
	end

	// merge accesses for the two touched pages
	always_comb begin
		op0.is_read  = 1'b0;
		op0.rd_zero  = 1'b0;
		op0.xor_mode = (cfg.draw_mode == msblt_pkg::MODE_XOR);
		op0.addr     = addr0;
		op0.data     = bits[7:0];
		op0.mask     = mbits[7:0];
		op1          = op0;
		op1.addr     = addr1;
		op1.data     = bits[15:8];
		op1.mask     = mbits[15:8];
	end

	// stream counter advance
	always_comb begin
		col_inc = {1'b0, col} + 9'd1;
		pg_inc  = {1'b0, pg} + 6'd1;
		if (col_inc >= {1'b0, cfg.sprite_width}) begin
			col_next = 8'd0;
			pg_next  = (pg_inc >= pages) ? 5'd0 : pg_inc[4:0];
		end else begin
			col_next = col_inc[7:0];
			pg_next  = pg;
		end
	end

	// classify the item and build its job
	always_comb begin
		fb_in_range         = (msblt_pkg::addr_t'(fb_address) < msblt_pkg::addr_t'(FbBytes));
		job.op_a            = op0;
		job.op_b            = op1;
		job.two             = 1'b0;
		job_ok              = 1'b0;
		case (operation)
			msblt_pkg::OP_SPRITE: begin
				job.op_a = a_ok ? op0 : op1;
				job.two  = a_ok && b_ok;
				job_ok   = !empty && (a_ok || b_ok);
			end
			msblt_pkg::OP_WRITE: begin
				job.op_a.addr     = msblt_pkg::addr_t'(fb_address);
				job.op_a.data     = fb_data;
				job.op_a.mask     = 8'hFF;
				job.op_a.xor_mode = 1'b0;
				job_ok            = fb_in_range;
			end
			msblt_pkg::OP_READ: begin
				job.op_a.is_read  = 1'b1;
				job.op_a.rd_zero  = !fb_in_range;
				job.op_a.addr     = msblt_pkg::addr_t'(fb_address);
				job.op_a.xor_mode = 1'b0;
				job_ok            = 1'b1;
			end
			default: begin
				job_ok = 1'b0;
			end
		endcase
		job_push = accept && job_ok;
	end

	// source column and page of the next sprite byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_column_q <= 8'd0;
			src_page_q   <= 5'd0;
		end else if (accept && (operation == msblt_pkg::OP_SPRITE)) begin
			if (empty) begin
				src_column_q <= 8'd0;
				src_page_q   <= 5'd0;
			end else begin
				src_column_q <= col_next;
				src_page_q   <= pg_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/msblt_back.sv
// Blitter back: runs queued store accesses against the framebuffer memory,
// one access a cycle unless a read result waits on a stalled output, with a
// read stage, a merge/write stage and a result register. Depends on msblt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msblt_back #(
	parameter int SCREEN_WIDTH  = msblt_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = msblt_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 head_valid,
	input  msblt_pkg::job_t     head_job,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          read_data
);

	localparam int FbBytes = SCREEN_WIDTH * (SCREEN_HEIGHT / 8);
	localparam int Aw      = $clog2(FbBytes);

	logic [7:0]          mem_q [FbBytes];
	logic [7:0]          rd_s1;
	msblt_pkg::mem_op_t  op_s1;
	logic                vld_s1;
	logic                half_q;
	logic                wr_vld_q;
	msblt_pkg::addr_t    wr_addr_q;
	logic [7:0]          wr_data_q;
	logic                out_vld_q;
	logic [7:0]          out_data_q;

	msblt_pkg::mem_op_t  op_sel;
	logic                stall;
	logic                adv;
	logic                load;
	logic                do_write;
	logic [7:0]          old_byte;
	logic [7:0]          new_byte;

	assign out_valid = out_vld_q;
	assign read_data = out_data_q;

	// issue control: second access of a job follows the first
	always_comb begin
		op_sel   = half_q ? head_job.op_b : head_job.op_a;
		stall    = vld_s1 && op_s1.is_read && out_vld_q && !out_ready;
		adv      = !stall;
		load     = adv && head_valid;
		pop      = load && (half_q || !head_job.two);
		do_write = adv && vld_s1 && !op_s1.is_read;
	end

	// merge with forwarding of the last write from its register
	always_comb begin
		old_byte = (wr_vld_q && (wr_addr_q == op_s1.addr)) ? wr_data_q : rd_s1;
		new_byte = op_s1.xor_mode ? (old_byte ^ op_s1.data)
			: ((old_byte & ~op_s1.mask) | op_s1.data);
	end

	// framebuffer memory: one read and one write port
	always_ff @(posedge clk) begin
		if (load) begin
			rd_s1 <= mem_q[op_sel.addr[Aw-1:0]];
			op_s1 <= op_sel;
		end
		if (do_write) begin
			mem_q[op_s1.addr[Aw-1:0]] <= new_byte;
		end
		if (adv) begin
			wr_addr_q <= op_s1.addr;
			wr_data_q <= new_byte;
		end
		if (adv && vld_s1 && op_s1.is_read) begin
			out_data_q <= op_s1.rd_zero ? 8'd0 : old_byte;
		end
	end

	// stage valids, job half and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			half_q    <= 1'b0;
			wr_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1   <= head_valid;
				wr_vld_q <= do_write;
			end
			if (load) begin
				half_q <= !half_q && head_job.two;
			end
			if (adv && vld_s1 && op_s1.is_read) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/masked_sprite_page_blitter_unit.sv
// Top level of the masked sprite page blitter: configuration registers,
// front, job queue and back. Depends on msblt_pkg and the msblt_* modules.
`timescale 1ns / 1ps
`default_nettype none

// The blitter holds a page-organized monochrome framebuffer of
// SCREEN_WIDTH * SCREEN_HEIGHT / 8 bytes (byte address page * SCREEN_WIDTH +
// column, bit 0 on top). Each input transfer carries an operation in tuser:
// sprite byte, framebuffer write or framebuffer read; only a read gives an
// output transfer. Software must write every framebuffer byte before a blit or
// a read touches it, since the memory is not cleared at reset. The front takes
// one transfer a cycle while the four-entry job queue has room. The back runs
// one framebuffer access a cycle while no read result waits on a stalled
// output, through a memory with one read and one write port; a sprite byte on
// two pages takes two accesses, every other queued item one. A read result
// goes through the queue entry, read stage and result register to the output.
// The user must write registers only while no item is in flight; the block
// does not enforce it. Sprite stream position is kept across register writes.
module masked_sprite_page_blitter_unit #(
	parameter int SCREEN_WIDTH  = msblt_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = msblt_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata,   // sprite_byte[7:0], mask_byte[15:8],
	                                    // fb_address[25:16], fb_data[33:26], zero pad
	input  wire  [1:0]  s_axis_tuser,   // operation[1:0]
	// result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata    // read_data[7:0]
);

	msblt_pkg::cfg_t  cfg_q;
	logic             cfg_wr;
	logic [2:0]       reg_idx;

	logic             q_full;
	logic             job_push;
	msblt_pkg::job_t  job;
	logic             q_valid;
	msblt_pkg::job_t  head_job;
	logic             job_pop;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x         <= 9'sd0;
			cfg_q.pos_y         <= 8'sd0;
			cfg_q.sprite_width  <= 8'd8;
			cfg_q.sprite_height <= 8'd8;
			cfg_q.mirror_h      <= 1'b0;
			cfg_q.mirror_v      <= 1'b0;
			cfg_q.draw_mode     <= msblt_pkg::MODE_NORMAL;
			cfg_q.has_mask      <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				msblt_pkg::REG_POS_X:     cfg_q.pos_x         <= pwdata[8:0];
				msblt_pkg::REG_POS_Y:     cfg_q.pos_y         <= pwdata[7:0];
				msblt_pkg::REG_SPRITE_W:  cfg_q.sprite_width  <= pwdata[7:0];
				msblt_pkg::REG_SPRITE_H:  cfg_q.sprite_height <= pwdata[7:0];
				msblt_pkg::REG_MIRROR_H:  cfg_q.mirror_h      <= pwdata[0];
				msblt_pkg::REG_MIRROR_V:  cfg_q.mirror_v      <= pwdata[0];
				msblt_pkg::REG_DRAW_MODE: cfg_q.draw_mode     <= pwdata[1:0];
				msblt_pkg::REG_HAS_MASK:  cfg_q.has_mask      <= pwdata[0];
				default:                  cfg_q               <= cfg_q;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			msblt_pkg::REG_POS_X:     prdata = {23'd0, cfg_q.pos_x};
			msblt_pkg::REG_POS_Y:     prdata = {24'd0, cfg_q.pos_y};
			msblt_pkg::REG_SPRITE_W:  prdata = {24'd0, cfg_q.sprite_width};
			msblt_pkg::REG_SPRITE_H:  prdata = {24'd0, cfg_q.sprite_height};
			msblt_pkg::REG_MIRROR_H:  prdata = {31'd0, cfg_q.mirror_h};
			msblt_pkg::REG_MIRROR_V:  prdata = {31'd0, cfg_q.mirror_v};
			msblt_pkg::REG_DRAW_MODE: prdata = {30'd0, cfg_q.draw_mode};
			msblt_pkg::REG_HAS_MASK:  prdata = {31'd0, cfg_q.has_mask};
			default:                  prdata = 32'd0;
		endcase
	end

	msblt_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.operation   (s_axis_tuser),
		.sprite_byte (s_axis_tdata[7:0]),
		.mask_byte   (s_axis_tdata[15:8]),
		.fb_address  (s_axis_tdata[25:16]),
		.fb_data     (s_axis_tdata[33:26]),
		.queue_full  (q_full),
		.job_push    (job_push),
		.job         (job)
	);

	msblt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.full       (q_full),
		.pop        (job_pop),
		.head_valid (q_valid),
		.head_job   (head_job)
	);

	msblt_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head_job   (head_job),
		.pop        (job_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.read_data  (m_axis_tdata)
	);

	// the front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) job_push |-> !q_full)
		else $error("job pushed into full queue");

	// the back never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) job_pop |-> q_valid)
		else $error("job popped from empty queue");

	// a two-access job left at the head of a queue that is not full stays queued until it is popped
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && head_job.two && !job_pop && !q_full) |=> q_valid)
		else $error("queued job lost");

endmodule

`default_nettype wire
